// File: sv/slcp_pkg.sv
`timescale 1ns / 1ps
package slcp_pkg;

  localparam int unsigned LEN_W = 8;

  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_V   = 8'h56;
  localparam logic [7:0] CH_N   = 8'h4E;
  localparam logic [7:0] CH_O   = 8'h4F;
  localparam logic [7:0] CH_C   = 8'h43;
  localparam logic [7:0] CH_T_STD = 8'h74;
  localparam logic [7:0] CH_T_EXT = 8'h54;

  localparam logic [15:0] VERSION_RESET = 16'h1013;
  localparam logic [15:0] SERIAL_RESET  = 16'h1234;

  // Register indexes on the configuration port.
  localparam logic REG_VERSION = 1'b0;
  localparam logic REG_SERIAL  = 1'b1;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             acc;
  } job_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  reply_byte;
    logic [28:0] frame_id;
    logic        frame_extended;
    logic [3:0]  frame_length;
    logic [63:0] frame_payload;
    logic        last;
  } result_t;

  typedef enum logic [2:0] {
    R_NONE,
    R_BEL,
    R_CR,
    R_WORD,
    R_FRAME
  } reply_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_C0,
    B_ID,
    B_DLC,
    B_DATA,
    B_EMIT
  } back_state_t;

  // Returns the nibble value in bits 3:0 and a valid flag in bit 4.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) r = 8'h30 + {4'd0, n};
    else r = 8'h37 + {4'd0, n};
    return r;
  endfunction

endpackage

// File: sv/slcp_byte_if.sv
`timescale 1ns / 1ps
interface slcp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       tx_accepted;

  modport source (output valid, output in_byte, output tx_accepted, input ready);
  modport sink (input valid, input in_byte, input tx_accepted, output ready);
endinterface

// File: sv/slcp_result_if.sv
`timescale 1ns / 1ps
interface slcp_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  reply_byte;
  logic [28:0] frame_id;
  logic        frame_extended;
  logic [3:0]  frame_length;
  logic [63:0] frame_payload;
  logic        last;

  modport source (output valid, output kind, output reply_byte, output frame_id,
                  output frame_extended, output frame_length, output frame_payload,
                  output last, input ready);
  modport sink (input valid, input kind, input reply_byte, input frame_id,
                input frame_extended, input frame_length, input frame_payload,
                input last, output ready);
endinterface

// File: sv/slcp_ram.sv
`timescale 1ns / 1ps
module slcp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: sv/slcp_front.sv
`timescale 1ns / 1ps
module slcp_front #(
  parameter int unsigned LINE_BYTES = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  slcp_byte_if.sink                     uart,
  input  logic                          back_busy,
  input  logic                          job_pop,
  output logic                          job_valid,
  output slcp_pkg::job_t                job,
  output logic                          we,
  output logic [$clog2(LINE_BYTES)-1:0] waddr,
  output logic [7:0]                    wdata
);
  import slcp_pkg::*;

  localparam int unsigned AW = $clog2(LINE_BYTES);

  logic [AW-1:0] line_count;
  logic          accept;
  logic          term;

  // The store is shared with the back end, so no byte is taken while a line is pending.
  assign uart.ready = !job_valid && !back_busy;
  assign accept = uart.valid && uart.ready;
  assign term = (uart.in_byte == CH_CR) || (uart.in_byte == CH_LF) ||
                (line_count == AW'(LINE_BYTES - 1));

  assign we = accept;
  assign waddr = line_count;
  assign wdata = uart.in_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count <= '0;
      job_valid <= 1'b0;
    end else begin
      if (job_pop) job_valid <= 1'b0;
      if (accept) begin
        if (term) begin
          line_count <= '0;
          job_valid <= 1'b1;
        end else begin
          line_count <= line_count + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && term) begin
      job.len <= LEN_W'(line_count);
      job.acc <= uart.tx_accepted;
    end
  end
endmodule

// File: sv/slcp_back.sv
`timescale 1ns / 1ps
module slcp_back #(
  parameter int unsigned LINE_BYTES = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          job_valid,
  input  slcp_pkg::job_t                job,
  output logic                          job_pop,
  output logic                          back_busy,
  output logic [$clog2(LINE_BYTES)-1:0] raddr,
  input  logic [7:0]                    rdata,
  input  logic [15:0]                   version_word,
  input  logic [15:0]                   serial_word,
  slcp_result_if.source                 result
);
  import slcp_pkg::*;

  localparam int unsigned AW = $clog2(LINE_BYTES);

  back_state_t      state, state_next;
  reply_t           code, code_next;
  logic [AW-1:0]    pos, pos_next;
  logic [LEN_W-1:0] len, len_next;
  logic             acc, acc_next;
  logic [7:0]       c0, c0_next;
  logic             ext, ext_next;
  logic [31:0]      id, id_next;
  logic [3:0]       dlc, dlc_next;
  logic [3:0]       cnt, cnt_next;
  logic [63:0]      payload, payload_next;
  logic [15:0]      word, word_next;
  logic [2:0]       step, step_next;

  result_t          out_reg, item;
  logic             out_valid;
  logic             out_free;
  logic             load;
  logic [4:0]       hv;
  logic [3:0]       digits;
  logic [8:0]       need;
  logic [2:0]       nbody;
  logic [5:0]       nib_base;

  assign out_free = !out_valid || result.ready;
  assign hv = hex_value(rdata);
  assign digits = ext ? 4'd8 : 4'd3;
  // Read address follows the next position, so the data of that position is there next cycle.
  assign raddr = pos_next;
  assign back_busy = (state != B_IDLE);
  assign nib_base = {cnt[3:1], ~cnt[0], 2'b00};

  always_comb begin
    case (code)
      R_NONE:  nbody = 3'd0;
      R_WORD:  nbody = 3'd6;
      R_FRAME: nbody = 3'd2;
      default: nbody = 3'd1;
    endcase
  end

  always_comb begin
    item = '0;
    if (step == nbody) begin
      item.reply_byte = CH_CR;
    end else if (step > nbody) begin
      item.reply_byte = CH_LF;
      item.last = 1'b1;
    end else begin
      case (code)
        R_BEL: item.reply_byte = CH_BEL;
        R_CR:  item.reply_byte = CH_CR;
        R_WORD: begin
          case (step)
            3'd0:    item.reply_byte = c0;
            3'd1:    item.reply_byte = hex_char(word[15:12]);
            3'd2:    item.reply_byte = hex_char(word[11:8]);
            3'd3:    item.reply_byte = hex_char(word[7:4]);
            3'd4:    item.reply_byte = hex_char(word[3:0]);
            default: item.reply_byte = CH_CR;
          endcase
        end
        R_FRAME: begin
          if (step == 3'd0) begin
            item.kind = 1'b1;
            item.frame_id = ext ? id[28:0] : {18'd0, id[10:0]};
            item.frame_extended = ext;
            item.frame_length = dlc;
            item.frame_payload = payload;
          end else begin
            item.reply_byte = CH_CR;
          end
        end
        default: item.reply_byte = CH_BEL;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    code_next = code;
    pos_next = pos;
    len_next = len;
    acc_next = acc;
    c0_next = c0;
    ext_next = ext;
    id_next = id;
    dlc_next = dlc;
    cnt_next = cnt;
    payload_next = payload;
    word_next = word;
    step_next = step;
    job_pop = 1'b0;
    load = 1'b0;
    need = 9'({digits, 1'b0}) + 9'd0;
    case (state)
      B_IDLE: begin
        if (job_valid) begin
          job_pop = 1'b1;
          len_next = job.len;
          acc_next = job.acc;
          pos_next = '0;
          step_next = '0;
          if (job.len == '0) begin
            code_next = R_NONE;
            state_next = B_EMIT;
          end else begin
            state_next = B_C0;
          end
        end
      end
      B_C0: begin
        c0_next = rdata;
        id_next = '0;
        payload_next = '0;
        dlc_next = '0;
        cnt_next = '0;
        state_next = B_EMIT;
        code_next = R_BEL;
        if (len == LEN_W'(1) && rdata == CH_V) begin
          code_next = R_WORD;
          word_next = version_word;
        end else if (len == LEN_W'(1) && rdata == CH_N) begin
          code_next = R_WORD;
          word_next = serial_word;
        end else if (len == LEN_W'(1) && (rdata == CH_O || rdata == CH_C)) begin
          code_next = R_CR;
        end else if (rdata == CH_T_STD || rdata == CH_T_EXT) begin
          ext_next = (rdata == CH_T_EXT);
          if (9'(len) >= ((rdata == CH_T_EXT) ? 9'd10 : 9'd5)) begin
            pos_next = AW'(1);
            state_next = B_ID;
          end
        end
      end
      B_ID: begin
        if (!hv[4]) begin
          code_next = R_BEL;
          state_next = B_EMIT;
        end else begin
          id_next = {id[27:0], hv[3:0]};
          pos_next = pos + AW'(1);
          if (cnt == digits - 4'd1) begin
            state_next = B_DLC;
          end else begin
            cnt_next = cnt + 4'd1;
          end
        end
      end
      B_DLC: begin
        need = 9'(digits) + 9'd2 + {4'd0, hv[3:0], 1'b0};
        dlc_next = hv[3:0];
        cnt_next = '0;
        if (!hv[4] || hv[3:0] > 4'd8 || 9'(len) < need) begin
          code_next = R_BEL;
          state_next = B_EMIT;
        end else if (hv[3:0] == 4'd0) begin
          code_next = acc ? R_FRAME : R_BEL;
          state_next = B_EMIT;
        end else begin
          pos_next = pos + AW'(1);
          state_next = B_DATA;
        end
      end
      B_DATA: begin
        if (!hv[4]) begin
          code_next = R_BEL;
          state_next = B_EMIT;
        end else begin
          payload_next[nib_base +: 4] = hv[3:0];
          if (cnt == {dlc[2:0], 1'b0} - 4'd1) begin
            code_next = acc ? R_FRAME : R_BEL;
            state_next = B_EMIT;
          end else begin
            cnt_next = cnt + 4'd1;
            pos_next = pos + AW'(1);
          end
        end
      end
      B_EMIT: begin
        if (out_free) begin
          load = 1'b1;
          step_next = step + 3'd1;
          if (item.last) state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    code <= code_next;
    pos <= pos_next;
    len <= len_next;
    acc <= acc_next;
    c0 <= c0_next;
    ext <= ext_next;
    id <= id_next;
    dlc <= dlc_next;
    cnt <= cnt_next;
    payload <= payload_next;
    word <= word_next;
    step <= step_next;
    if (load) out_reg <= item;
  end

  assign result.valid = out_valid;
  assign result.kind = out_reg.kind;
  assign result.reply_byte = out_reg.reply_byte;
  assign result.frame_id = out_reg.frame_id;
  assign result.frame_extended = out_reg.frame_extended;
  assign result.frame_length = out_reg.frame_length;
  assign result.frame_payload = out_reg.frame_payload;
  assign result.last = out_reg.last;
endmodule

// File: sv/slcan_command_line_parser_core.sv
`timescale 1ns / 1ps
// SLCAN command line parser.
// The uart channel takes one received character per transaction together with
// the transmit mailbox status. The result channel gives response characters
// (kind 0) and CAN frames to send (kind 1); last marks the final result of the
// character that ended a line. version_word and serial_word are written over
// the APB port at byte addresses 0 and 4; they are to be written only while
// the block is idle, which the block itself does not enforce. A character
// that does not end a line is stored and gives no result. A line end (CR, LF,
// or a full line) hands the line to the parser, which walks the stored
// characters one per cycle from the line store RAM and then loads one result
// per cycle, while the receiver takes them, into the output register: 2 to 8
// results. The uart channel takes no new character until the last result of
// a line has been loaded. When the receiver stalls, the output register holds
// its result and the parser waits. Reset empties the line, drops any pending
// result and restores the register defaults; the line store itself is not
// cleared.
module slcan_command_line_parser_core #(
  parameter int unsigned LINE_BYTES = 32
) (
  input  logic          clk,
  input  logic          rst,
  slcp_byte_if.sink     uart,
  slcp_result_if.source result,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import slcp_pkg::*;

  localparam int unsigned AW = $clog2(LINE_BYTES);

  logic [15:0]   version_word;
  logic [15:0]   serial_word;
  logic          job_valid;
  logic          job_pop;
  logic          back_busy;
  job_t          job;
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [7:0]    wdata;
  logic [7:0]    rdata;

  assign pready = 1'b1;
  assign prdata = {16'd0, (paddr[2] == REG_SERIAL) ? serial_word : version_word};

  always_ff @(posedge clk) begin
    if (rst) begin
      version_word <= VERSION_RESET;
      serial_word <= SERIAL_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_VERSION) version_word <= pwdata[15:0];
      else serial_word <= pwdata[15:0];
    end
  end

  slcp_front #(.LINE_BYTES(LINE_BYTES)) u_front (
    .clk(clk), .rst(rst), .uart(uart), .back_busy(back_busy), .job_pop(job_pop),
    .job_valid(job_valid), .job(job), .we(we), .waddr(waddr), .wdata(wdata)
  );

  slcp_ram #(.WIDTH(8), .DEPTH(LINE_BYTES)) u_line_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  slcp_back #(.LINE_BYTES(LINE_BYTES)) u_back (
    .clk(clk), .rst(rst), .job_valid(job_valid), .job(job), .job_pop(job_pop),
    .back_busy(back_busy), .raddr(raddr), .rdata(rdata),
    .version_word(version_word), .serial_word(serial_word), .result(result)
  );
endmodule

// File: sv/slcp_checker.sv
`timescale 1ns / 1ps
module slcp_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_kind,
  input logic out_last,
  input logic pready
);
  // A held result must stay offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // While a line is still being answered, no new character is taken.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> !in_ready) else $error("input taken mid response");

  a_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind |-> !out_last) else $error("frame marked as final result");

  a_pready: assert property (@(posedge clk) pready) else $error("pready low");
endmodule

bind slcan_command_line_parser_core slcp_checker u_checker (
  .clk(clk), .rst(rst), .in_ready(uart.ready), .out_valid(result.valid),
  .out_ready(result.ready), .out_kind(result.kind), .out_last(result.last),
  .pready(pready)
);

// File: tb/tb_slcan_command_line_parser_core.sv
`timescale 1ns / 1ps
module tb_slcan_command_line_parser_core;
  import slcp_pkg::*;

  localparam int unsigned LINE_BYTES = 32;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [7:0] ch;
    logic       acc;
  } uart_item_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  slcp_byte_if uart_ch ();
  slcp_result_if result_ch ();

  slcan_command_line_parser_core #(.LINE_BYTES(LINE_BYTES)) dut (
    .clk(clk), .rst(rst), .uart(uart_ch.sink), .result(result_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Parser copy held by the testbench.
  logic [7:0] line_buf [LINE_BYTES];
  int unsigned line_len;
  logic [15:0] version_reg;
  logic [15:0] serial_reg;

  uart_item_t pending_chars[$];
  result_t expected_results[$];

  int unsigned errors;
  int unsigned result_count;
  int unsigned frame_count;
  int unsigned line_count_seen;
  int unsigned cycle;
  bit idle_free;

  task automatic report_mismatch(input string what);
    errors++;
    $display("MISMATCH at cycle %0d: %s", cycle, what);
  endtask

  function automatic result_t reply(input logic [7:0] b);
    result_t r;
    r = '0;
    r.reply_byte = b;
    return r;
  endfunction

  function automatic int nib(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return 16;
  endfunction

  function automatic logic [7:0] hexc(input logic [3:0] n);
    return (n < 10) ? 8'h30 + n : 8'h37 + n;
  endfunction

  task automatic push_word(input logic [7:0] letter, input logic [15:0] w);
    expected_results.push_back(reply(letter));
    for (int k = 3; k >= 0; k--) expected_results.push_back(reply(hexc(w[4*k +: 4])));
    expected_results.push_back(reply(CH_CR));
  endtask

  task automatic predict_frame(input int unsigned len, input bit ext, input bit acc);
    int unsigned digits;
    int v, dlc, hi, lo;
    logic [31:0] id;
    logic [63:0] payload;
    result_t r;
    digits = ext ? 8 : 3;
    id = 0;
    payload = 0;
    if (len < digits + 2) begin
      expected_results.push_back(reply(CH_BEL));
      return;
    end
    for (int i = 0; i < digits; i++) begin
      v = nib(line_buf[1 + i]);
      if (v > 15) begin
        expected_results.push_back(reply(CH_BEL));
        return;
      end
      id = (id << 4) | v;
    end
    dlc = nib(line_buf[1 + digits]);
    if (dlc > 8 || len < digits + 2 + 2 * dlc) begin
      expected_results.push_back(reply(CH_BEL));
      return;
    end
    for (int i = 0; i < dlc; i++) begin
      hi = nib(line_buf[digits + 2 + 2 * i]);
      lo = nib(line_buf[digits + 3 + 2 * i]);
      if (hi > 15 || lo > 15) begin
        expected_results.push_back(reply(CH_BEL));
        return;
      end
      payload[8 * i +: 8] = 8'((hi << 4) | lo);
    end
    if (!acc) begin
      expected_results.push_back(reply(CH_BEL));
      return;
    end
    r = '0;
    r.kind = 1'b1;
    r.frame_id = ext ? id[28:0] : {18'd0, id[10:0]};
    r.frame_extended = ext;
    r.frame_length = 4'(dlc);
    r.frame_payload = payload;
    expected_results.push_back(r);
    expected_results.push_back(reply(CH_CR));
  endtask

  task automatic predict_char(input uart_item_t it);
    logic [7:0] c0;
    result_t r;
    line_buf[line_len] = it.ch;
    if (it.ch == CH_CR || it.ch == CH_LF || line_len == LINE_BYTES - 1) begin
      line_count_seen++;
      if (line_len > 0) begin
        c0 = line_buf[0];
        if (line_len == 1 && c0 == CH_V) push_word(CH_V, version_reg);
        else if (line_len == 1 && c0 == CH_N) push_word(CH_N, serial_reg);
        else if (line_len == 1 && (c0 == CH_O || c0 == CH_C))
          expected_results.push_back(reply(CH_CR));
        else if (c0 == CH_T_STD) predict_frame(line_len, 1'b0, it.acc);
        else if (c0 == CH_T_EXT) predict_frame(line_len, 1'b1, it.acc);
        else expected_results.push_back(reply(CH_BEL));
      end
      expected_results.push_back(reply(CH_CR));
      r = reply(CH_LF);
      r.last = 1'b1;
      expected_results.push_back(r);
      line_len = 0;
    end else begin
      line_len++;
    end
  endtask

  task automatic add_line(input string s, input bit acc);
    uart_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.ch = s[i];
      it.acc = acc;
      pending_chars.push_back(it);
    end
  endtask

  function automatic string rand_hex(input int n);
    string s;
    byte c;
    s = "";
    for (int i = 0; i < n; i++) begin
      c = hexc(4'($urandom_range(0, 15)));
      if (c >= "A" && $urandom_range(0, 1)) c = c + 8'h20;
      s = {s, string'(c)};
    end
    return s;
  endfunction

  task automatic add_random_line();
    string s;
    string lead;
    string tail;
    int dlc, sel;
    bit ext;
    byte c;
    sel = $urandom_range(0, 99);
    ext = $urandom_range(0, 1);
    if (sel < 60) begin
      dlc = $urandom_range(0, 9);
      lead = ext ? "T" : "t";
      s = {lead, rand_hex(ext ? 8 : 3), string'(byte'(hexc(4'(dlc)))),
           rand_hex(2 * (dlc > 8 ? 8 : dlc))};
      // Occasionally break the line: a bad digit, a cut, or trailing text.
      if ($urandom_range(0, 7) == 0) s[$urandom_range(1, s.len() - 1)] = "x";
      if ($urandom_range(0, 7) == 0 && s.len() > 2) s = s.substr(0, s.len() - 2);
      if ($urandom_range(0, 9) == 0) s = {s, "zz"};
    end else if (sel < 75) begin
      case ($urandom_range(0, 3))
        0: s = "V";
        1: s = "N";
        2: s = "O";
        default: s = "C";
      endcase
    end else begin
      s = "";
      for (int i = $urandom_range(0, 5); i > 0; i--) begin
        c = byte'($urandom_range(0, 255));
        if (c == CH_CR || c == CH_LF) c = "S";
        s = {s, string'(c)};
      end
    end
    tail = $urandom_range(0, 1) ? "\r" : "\n";
    add_line({s, tail}, $urandom_range(0, 5) != 0);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == 3'd0) version_reg = data[15:0];
    else serial_reg = data[15:0];
  endtask

  task automatic drain();
    while (!(pending_chars.size() == 0 && !uart_ch.valid && expected_results.size() == 0))
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Driver: one character per transaction, prediction at acceptance.
  always @(posedge clk) begin
    if (rst) begin
      uart_ch.valid <= 1'b0;
    end else begin
      if (uart_ch.valid && uart_ch.ready) predict_char('{uart_ch.in_byte, uart_ch.tx_accepted});
      if (!uart_ch.valid || uart_ch.ready) begin
        if (pending_chars.size() > 0 && (idle_free || $urandom_range(0, 99) >= 19)) begin
          uart_item_t it;
          it = pending_chars.pop_front();
          uart_ch.valid <= 1'b1;
          uart_ch.in_byte <= it.ch;
          uart_ch.tx_accepted <= it.acc;
        end else begin
          uart_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        result_t got, exp_r;
        got = '{result_ch.kind, result_ch.reply_byte, result_ch.frame_id,
                result_ch.frame_extended, result_ch.frame_length,
                result_ch.frame_payload, result_ch.last};
        result_count++;
        if (got.kind) frame_count++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", got));
        end else begin
          exp_r = expected_results.pop_front();
          if (got.kind != exp_r.kind) report_mismatch("kind");
          if (got.reply_byte != exp_r.reply_byte)
            report_mismatch($sformatf("reply_byte %h exp %h", got.reply_byte, exp_r.reply_byte));
          if (got.frame_id != exp_r.frame_id)
            report_mismatch($sformatf("frame_id %h exp %h", got.frame_id, exp_r.frame_id));
          if (got.frame_extended != exp_r.frame_extended) report_mismatch("frame_extended");
          if (got.frame_length != exp_r.frame_length) report_mismatch("frame_length");
          if (got.frame_payload != exp_r.frame_payload)
            report_mismatch($sformatf("frame_payload %h exp %h",
                                      got.frame_payload, exp_r.frame_payload));
          if (got.last != exp_r.last) report_mismatch("last");
        end
      end
      result_ch.ready <= idle_free || ($urandom_range(0, 99) >= 19);
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("timeout");
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    uart_ch.valid = 0; uart_ch.in_byte = 0; uart_ch.tx_accepted = 0;
    result_ch.ready = 0;
    cycle = 0; errors = 0; result_count = 0; frame_count = 0; line_count_seen = 0;
    line_len = 0; idle_free = 0;
    version_reg = VERSION_RESET;
    serial_reg = SERIAL_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed lines at reset register values.
    add_line("V\r", 1);
    add_line("N\n", 1);
    add_line("\r", 1);
    add_line("O\r", 1);
    add_line("C\n", 1);
    add_line("t7FF8FFFFFFFFFFFFFFFF\r", 1);
    add_line("TFFFFFFFF0\r", 1);
    add_line("t1230\r", 0);
    add_line("t12G1AA\r", 1);
    add_line("t1239\r", 1);
    add_line("t12320A\r", 1);
    add_line("t12301xyz\r", 1);
    add_line("Vx\r", 1);
    add_line("S6\r", 1);
    add_line({"t0004", {27{"A"}}}, 1);
    add_line({31{"\x80"}}, 1);
    add_line("\x7f\r", 1);
    drain();

    apb_write(3'd0, 32'h0000);
    apb_write(3'd4, 32'hFFFF);
    add_line("V\rN\r", 1);
    drain();
    apb_write(3'd0, 32'hFFFF_ABCD);
    apb_write(3'd4, 32'h0000_0000);
    add_line("V\rN\r", 1);
    // Sender waits for every result before going on.
    drain();

    apb_write(3'd0, 32'h5A3C);
    apb_write(3'd4, 32'h96E1);
    while (pending_chars.size() < 35) add_random_line();
    drain();
    idle_free = 1;
    while (pending_chars.size() < 30) add_random_line();
    drain();
    idle_free = 0;
    while (pending_chars.size() < 35) add_random_line();
    drain();

    $display("Covered %0d lines, %0d results of which %0d CAN frames.",
             line_count_seen, result_count, frame_count);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/slcp_pkg.sv
sv/slcp_byte_if.sv
sv/slcp_result_if.sv
sv/slcp_ram.sv
sv/slcp_front.sv
sv/slcp_back.sv
sv/slcan_command_line_parser_core.sv
sv/slcp_checker.sv
tb/tb_slcan_command_line_parser_core.sv
